@@ hdl/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
// Each macro wraps one clocked concurrent assertion on clk with reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define FFEA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FFEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ffea_pkg.sv @@
// Package for the first-fit extent allocator: sizes, codes and the
// controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps
package ffea_pkg;

  localparam int MAX_EXTENTS = 64;
  localparam int ADDR_W      = $clog2(MAX_EXTENTS);
  localparam int IDX_W       = ADDR_W + 1;
  localparam int START_W     = 23;
  localparam int LEN_W       = 24;
  localparam int ENT_W       = START_W + LEN_W;
  localparam int UNIT_SHIFT  = 4;
  localparam int NEED_W      = 33 - UNIT_SHIFT;
  localparam logic [LEN_W-1:0] POOL_CAP   = 24'd8388608;
  localparam logic [LEN_W-1:0] POOL_RESET = 24'd8388608;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_INIT  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_ZERO    = 3'd2,
    ST_RANGE   = 3'd3,
    ST_OVERLAP = 3'd4,
    ST_FULL    = 3'd5
  } st_code_t;

  typedef enum logic [3:0] {
    S_BOOT, S_IDLE, S_DISP, S_A_RD, S_A_CHK, S_SD_RD, S_SD_WR,
    S_F_RD, S_F_CHK, S_F_DEC, S_SU_RD, S_SU_WR, S_FIN
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_INIT, DP_RD_IDX, DP_NEXT, DP_CARVE, DP_TAKE,
    DP_RD_DOWN, DP_WR_DOWN, DP_DEC, DP_ADV_PREV, DP_CAP_NEXT,
    DP_WR_MERGE2, DP_WR_PREV, DP_WR_NEXTJ, DP_SETJ, DP_RD_UP, DP_WR_UP,
    DP_WR_INS, DP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t   op;
    st_code_t code;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  zero_req;
    logic  bad_range;
    logic  fit;
    logic  exact;
    logic  idx_end;
    logic  past_h;
    logic  more_down;
    logic  j_above;
    logic  overlap;
    logic  join_prev;
    logic  join_next;
    logic  full;
    logic  out_busy;
  } dp_stat_t;

endpackage

@@ hdl/first_fit_extent_allocator_top.sv @@
// Channel | Dir | Fields (low bit up)
// in_     | in  | tdata: mode[1:0] request_bytes[33:2] payload_offset[57:34] block_units[81:58]
// out_    | out | tdata: status[2:0] result_offset[26:3] result_units[50:27]
// cfg_    | in  | wdata: pool_units[23:0], written when cfg_we is high
// One beat at a time; the work per beat grows with the extents scanned or shifted, as the
// controller steps through the table RAM, which has one write port and a registered read.
// After reset the first extent is written to the table in S_BOOT, in the cycle before in_tready rises.
// A result waits in the output register; a stalled out_ side holds only the next finish.
// Top level of the first-fit extent allocator; depends on ffea_pkg, ffea_ctrl,
// ffea_datapath and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module first_fit_extent_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mode, request_bytes, payload_offset, block_units, zero fill
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status, result_offset, result_units, zero fill
  output logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata
);

  ffea_pkg::dp_cmd_t  cmd;
  ffea_pkg::dp_stat_t stat;

  ffea_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .cmd(cmd), .stat(stat)
  );

  ffea_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_tdata(in_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_tdata(out_tdata)
  );

  `FFEA_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "second beat taken early")
  `FFEA_ASSERT_NOW(a_no_overwrite, cmd.op == ffea_pkg::DP_RESULT, !stat.out_busy, "result overwritten")
  `FFEA_ASSERT_NEXT(a_result_shown, cmd.op == ffea_pkg::DP_RESULT, out_tvalid, "result not shown")

endmodule

@@ hdl/ffea_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ffea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/ffea_datapath.sv @@
// Allocator datapath: extent table RAM, scan and shift registers, result register.
// Depends on ffea_pkg and ffea_ram; driven by ffea_ctrl commands.
`timescale 1ns / 1ps
module ffea_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  ffea_pkg::dp_cmd_t cmd,
  output ffea_pkg::dp_stat_t stat,
  input  logic [87:0]       in_tdata,
  input  logic              cfg_we,
  input  logic [23:0]       cfg_wdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [55:0]       out_tdata
);

  localparam int AW = ffea_pkg::ADDR_W;
  localparam int IW = ffea_pkg::IDX_W;
  localparam int SW = ffea_pkg::START_W;
  localparam int LW = ffea_pkg::LEN_W;
  localparam int NW = ffea_pkg::NEED_W;

  logic [LW-1:0] pool_r;
  logic [IW-1:0] count_r, idx_r, j_r;
  logic [1:0]    mode_r;
  logic          zero_r, pay_zero_r;
  logic [NW-1:0] need_r;
  logic [LW-1:0] h_r, units_r;
  logic [SW-1:0] prev_s_r, cur_s_r;
  logic [LW-1:0] prev_l_r, cur_l_r;
  logic          has_prev_r, has_next_r;
  logic [LW-1:0] alloc_off_r, alloc_units_r;
  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [LW-1:0] out_off_r, out_units_r;

  logic                    we;
  logic [AW-1:0]           waddr, raddr;
  logic [ffea_pkg::ENT_W-1:0] wdata, rdata;
  logic [SW-1:0]           rd_s;
  logic [LW-1:0]           rd_l, usable, new_len;
  logic [IW-1:0]           idx_m1, j_m1;
  logic [LW:0]             prev_end, h_end;
  logic [NW-1:0]           need_in;
  logic                    res_alloc;

  ffea_ram #(.WIDTH(ffea_pkg::ENT_W), .DEPTH(ffea_pkg::MAX_EXTENTS)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign rd_s     = rdata[ffea_pkg::ENT_W-1:LW];
  assign rd_l     = rdata[LW-1:0];
  assign usable   = (pool_r > ffea_pkg::POOL_CAP) ? ffea_pkg::POOL_CAP : pool_r;
  assign new_len  = rd_l - need_r[LW-1:0];
  assign idx_m1   = idx_r - IW'(1);
  assign j_m1     = j_r - IW'(1);
  assign prev_end = {2'b0, prev_s_r} + {1'b0, prev_l_r};
  assign h_end    = {1'b0, h_r} + {1'b0, units_r};
  assign need_in  = NW'(({1'b0, in_tdata[33:2]} + 33'd15) >> ffea_pkg::UNIT_SHIFT) + NW'(1);
  assign res_alloc = (cmd.code == ffea_pkg::ST_OK) && (mode_r == ffea_pkg::MODE_ALLOC);

  always_comb begin
    stat.mode      = ffea_pkg::mode_t'(mode_r);
    stat.zero_req  = zero_r;
    stat.bad_range = pay_zero_r || (units_r == '0) || (h_end > {1'b0, usable});
    stat.fit       = {{(NW-LW){1'b0}}, rd_l} >= need_r;
    stat.exact     = {{(NW-LW){1'b0}}, rd_l} == need_r;
    stat.idx_end   = idx_r == count_r;
    stat.past_h    = {1'b0, rd_s} > h_r;
    stat.more_down = ({1'b0, idx_r} + (IW+1)'(1)) < {1'b0, count_r};
    stat.j_above   = j_r > idx_r;
    stat.overlap   = (has_prev_r && (prev_end > {1'b0, h_r})) ||
                     (has_next_r && (h_end > {2'b0, cur_s_r}));
    stat.join_prev = has_prev_r && (prev_end == {1'b0, h_r});
    stat.join_next = has_next_r && (h_end == {2'b0, cur_s_r});
    stat.full      = count_r == IW'(ffea_pkg::MAX_EXTENTS);
    stat.out_busy  = out_valid_r && !out_tready;
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_r[AW-1:0];
    wdata = rdata;
    raddr = idx_r[AW-1:0];
    case (cmd.op)
      ffea_pkg::DP_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = {{SW{1'b0}}, usable};
      end
      ffea_pkg::DP_CARVE: begin
        we    = 1'b1;
        wdata = {rd_s, new_len};
      end
      ffea_pkg::DP_RD_DOWN:   raddr = AW'(idx_r + IW'(1));
      ffea_pkg::DP_WR_DOWN:   we = 1'b1;
      ffea_pkg::DP_WR_MERGE2: begin
        we    = 1'b1;
        waddr = idx_m1[AW-1:0];
        wdata = {prev_s_r, prev_l_r + units_r + cur_l_r};
      end
      ffea_pkg::DP_WR_PREV: begin
        we    = 1'b1;
        waddr = idx_m1[AW-1:0];
        wdata = {prev_s_r, prev_l_r + units_r};
      end
      ffea_pkg::DP_WR_NEXTJ: begin
        we    = 1'b1;
        wdata = {h_r[SW-1:0], cur_l_r + units_r};
      end
      ffea_pkg::DP_RD_UP:     raddr = j_m1[AW-1:0];
      ffea_pkg::DP_WR_UP: begin
        we    = 1'b1;
        waddr = j_r[AW-1:0];
      end
      ffea_pkg::DP_WR_INS: begin
        we    = 1'b1;
        wdata = {h_r[SW-1:0], units_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r      <= ffea_pkg::POOL_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        pool_r <= cfg_wdata;
      end
      if (cmd.op == ffea_pkg::DP_RESULT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        ffea_pkg::DP_LOAD: begin
          mode_r     <= in_tdata[1:0];
          zero_r     <= in_tdata[33:2] == '0;
          need_r     <= need_in;
          pay_zero_r <= in_tdata[57:34] == '0;
          h_r        <= in_tdata[57:34] - LW'(1);
          units_r    <= in_tdata[81:58];
          idx_r      <= '0;
          has_prev_r <= 1'b0;
          has_next_r <= 1'b0;
        end
        ffea_pkg::DP_INIT:     count_r <= (usable != '0) ? IW'(1) : '0;
        ffea_pkg::DP_NEXT:     idx_r <= idx_r + IW'(1);
        ffea_pkg::DP_CARVE: begin
          alloc_off_r   <= LW'({1'b0, rd_s} + new_len + LW'(1));
          alloc_units_r <= need_r[LW-1:0];
        end
        ffea_pkg::DP_TAKE: begin
          alloc_off_r   <= {1'b0, rd_s} + LW'(1);
          alloc_units_r <= need_r[LW-1:0];
        end
        ffea_pkg::DP_WR_DOWN:  idx_r <= idx_r + IW'(1);
        ffea_pkg::DP_DEC:      count_r <= count_r - IW'(1);
        ffea_pkg::DP_ADV_PREV: begin
          prev_s_r   <= rd_s;
          prev_l_r   <= rd_l;
          has_prev_r <= 1'b1;
          idx_r      <= idx_r + IW'(1);
        end
        ffea_pkg::DP_CAP_NEXT: begin
          cur_s_r    <= rd_s;
          cur_l_r    <= rd_l;
          has_next_r <= 1'b1;
        end
        ffea_pkg::DP_SETJ:     j_r <= count_r;
        ffea_pkg::DP_WR_UP:    j_r <= j_m1;
        ffea_pkg::DP_WR_INS:   count_r <= count_r + IW'(1);
        ffea_pkg::DP_RESULT: begin
          out_status_r <= cmd.code;
          out_off_r    <= res_alloc ? alloc_off_r : '0;
          out_units_r  <= res_alloc ? alloc_units_r : '0;
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_units_r, out_off_r, out_status_r};

endmodule

@@ hdl/ffea_ctrl.sv @@
// Allocator controller: sequences scans, shifts and table writes per beat.
// Depends on ffea_pkg; drives ffea_datapath through command and status structs.
`timescale 1ns / 1ps
module ffea_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output ffea_pkg::dp_cmd_t  cmd,
  input  ffea_pkg::dp_stat_t stat
);

  ffea_pkg::state_t   state_r, state_nxt;
  ffea_pkg::st_code_t code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffea_pkg::S_BOOT;
      code_r  <= ffea_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd.op    = ffea_pkg::DP_NOP;
    cmd.code  = code_r;
    in_tready = 1'b0;
    case (state_r)
      ffea_pkg::S_BOOT: begin
        cmd.op    = ffea_pkg::DP_INIT;
        state_nxt = ffea_pkg::S_IDLE;
      end
      ffea_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = ffea_pkg::DP_LOAD;
          state_nxt = ffea_pkg::S_DISP;
        end
      end
      ffea_pkg::S_DISP: begin
        code_nxt  = ffea_pkg::ST_OK;
        state_nxt = ffea_pkg::S_FIN;
        case (stat.mode)
          ffea_pkg::MODE_ALLOC: begin
            if (stat.zero_req) code_nxt = ffea_pkg::ST_ZERO;
            else state_nxt = ffea_pkg::S_A_RD;
          end
          ffea_pkg::MODE_FREE: begin
            if (stat.bad_range) code_nxt = ffea_pkg::ST_RANGE;
            else state_nxt = ffea_pkg::S_F_RD;
          end
          ffea_pkg::MODE_INIT: cmd.op = ffea_pkg::DP_INIT;
          default: ;
        endcase
      end
      ffea_pkg::S_A_RD: begin
        if (stat.idx_end) begin
          code_nxt  = ffea_pkg::ST_NOFIT;
          state_nxt = ffea_pkg::S_FIN;
        end else begin
          cmd.op    = ffea_pkg::DP_RD_IDX;
          state_nxt = ffea_pkg::S_A_CHK;
        end
      end
      ffea_pkg::S_A_CHK: begin
        if (stat.fit && !stat.exact) begin
          cmd.op    = ffea_pkg::DP_CARVE;
          code_nxt  = ffea_pkg::ST_OK;
          state_nxt = ffea_pkg::S_FIN;
        end else if (stat.fit) begin
          cmd.op    = ffea_pkg::DP_TAKE;
          state_nxt = ffea_pkg::S_SD_RD;
        end else begin
          cmd.op    = ffea_pkg::DP_NEXT;
          state_nxt = ffea_pkg::S_A_RD;
        end
      end
      ffea_pkg::S_SD_RD: begin
        if (stat.more_down) begin
          cmd.op    = ffea_pkg::DP_RD_DOWN;
          state_nxt = ffea_pkg::S_SD_WR;
        end else begin
          cmd.op    = ffea_pkg::DP_DEC;
          code_nxt  = ffea_pkg::ST_OK;
          state_nxt = ffea_pkg::S_FIN;
        end
      end
      ffea_pkg::S_SD_WR: begin
        cmd.op    = ffea_pkg::DP_WR_DOWN;
        state_nxt = ffea_pkg::S_SD_RD;
      end
      ffea_pkg::S_F_RD: begin
        if (stat.idx_end) begin
          state_nxt = ffea_pkg::S_F_DEC;
        end else begin
          cmd.op    = ffea_pkg::DP_RD_IDX;
          state_nxt = ffea_pkg::S_F_CHK;
        end
      end
      ffea_pkg::S_F_CHK: begin
        if (stat.past_h) begin
          cmd.op    = ffea_pkg::DP_CAP_NEXT;
          state_nxt = ffea_pkg::S_F_DEC;
        end else begin
          cmd.op    = ffea_pkg::DP_ADV_PREV;
          state_nxt = ffea_pkg::S_F_RD;
        end
      end
      ffea_pkg::S_F_DEC: begin
        code_nxt  = ffea_pkg::ST_OK;
        state_nxt = ffea_pkg::S_FIN;
        if (stat.overlap) begin
          code_nxt = ffea_pkg::ST_OVERLAP;
        end else if (stat.join_prev && stat.join_next) begin
          cmd.op    = ffea_pkg::DP_WR_MERGE2;
          state_nxt = ffea_pkg::S_SD_RD;
        end else if (stat.join_prev) begin
          cmd.op = ffea_pkg::DP_WR_PREV;
        end else if (stat.join_next) begin
          cmd.op = ffea_pkg::DP_WR_NEXTJ;
        end else if (stat.full) begin
          code_nxt = ffea_pkg::ST_FULL;
        end else begin
          cmd.op    = ffea_pkg::DP_SETJ;
          state_nxt = ffea_pkg::S_SU_RD;
        end
      end
      ffea_pkg::S_SU_RD: begin
        if (stat.j_above) begin
          cmd.op    = ffea_pkg::DP_RD_UP;
          state_nxt = ffea_pkg::S_SU_WR;
        end else begin
          cmd.op    = ffea_pkg::DP_WR_INS;
          code_nxt  = ffea_pkg::ST_OK;
          state_nxt = ffea_pkg::S_FIN;
        end
      end
      ffea_pkg::S_SU_WR: begin
        cmd.op    = ffea_pkg::DP_WR_UP;
        state_nxt = ffea_pkg::S_SU_RD;
      end
      ffea_pkg::S_FIN: begin
        if (!stat.out_busy) begin
          cmd.op    = ffea_pkg::DP_RESULT;
          state_nxt = ffea_pkg::S_IDLE;
        end
      end
      default: state_nxt = ffea_pkg::S_IDLE;
    endcase
  end

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the first-fit extent allocator top level.
// A scoreboard class predicts each result from its own copy of the extent
// table; depends on ffea_pkg and first_fit_extent_allocator_top.
`timescale 1ns / 1ps

class alloc_scoreboard;
  bit [23:0] pool_reg;
  bit [22:0] ext_start[64];
  bit [23:0] ext_len[64];
  int unsigned ext_count;
  bit [2:0]  q_status[$];
  bit [23:0] q_offset[$];
  bit [23:0] q_units[$];
  int unsigned errors;
  int unsigned results_seen;
  int unsigned ok_allocs;
  int unsigned ok_frees;
  bit [23:0] live_off[$];
  bit [23:0] live_units[$];

  function new();
    pool_reg = ffea_pkg::POOL_RESET;
    errors = 0;
    results_seen = 0;
    table_init();
  endfunction

  function bit [23:0] usable();
    return (pool_reg > ffea_pkg::POOL_CAP) ? ffea_pkg::POOL_CAP : pool_reg;
  endfunction

  function void table_init();
    bit [23:0] u;
    u = usable();
    for (int k = 0; k < 64; k++) begin
      ext_start[k] = '0;
      ext_len[k] = '0;
    end
    ext_len[0] = u;
    ext_count = (u != 0) ? 1 : 0;
    live_off.delete();
    live_units.delete();
  endfunction

  function void remove_entry(int unsigned i);
    for (int unsigned k = i; k + 1 < ext_count; k++) begin
      ext_start[k] = ext_start[k+1];
      ext_len[k] = ext_len[k+1];
    end
    ext_count--;
    ext_start[ext_count] = '0;
    ext_len[ext_count] = '0;
  endfunction

  function bit [2:0] alloc(bit [31:0] bytes, output bit [23:0] off, output bit [23:0] units);
    longint unsigned need;
    bit [23:0] blk;
    off = '0;
    units = '0;
    if (bytes == 0) return ffea_pkg::ST_ZERO;
    need = (longint'(bytes) + 15) / 16 + 1;
    for (int unsigned i = 0; i < ext_count; i++) begin
      if (ext_len[i] >= need) begin
        if (ext_len[i] > need) begin
          ext_len[i] = 24'(ext_len[i] - need);
          blk = ext_start[i] + ext_len[i];
        end else begin
          blk = ext_start[i];
          remove_entry(i);
        end
        off = blk + 24'd1;
        units = need[23:0];
        return ffea_pkg::ST_OK;
      end
    end
    return ffea_pkg::ST_NOFIT;
  endfunction

  function bit [2:0] free_blk(bit [23:0] payload, bit [23:0] units);
    longint unsigned h, pend;
    int unsigned i;
    bit hp, hn, jp, jn;
    if (payload == 0 || units == 0) return ffea_pkg::ST_RANGE;
    h = payload - 1;
    if (h + units > usable()) return ffea_pkg::ST_RANGE;
    i = 0;
    while (i < ext_count && ext_start[i] <= h) i++;
    hp = i > 0;
    hn = i < ext_count;
    pend = hp ? longint'(ext_start[i-1]) + ext_len[i-1] : 0;
    if (hp && pend > h) return ffea_pkg::ST_OVERLAP;
    if (hn && h + units > ext_start[i]) return ffea_pkg::ST_OVERLAP;
    jp = hp && pend == h;
    jn = hn && h + units == ext_start[i];
    if (jp && jn) begin
      ext_len[i-1] = ext_len[i-1] + units + ext_len[i];
      remove_entry(i);
    end else if (jp) begin
      ext_len[i-1] = ext_len[i-1] + units;
    end else if (jn) begin
      ext_start[i] = 23'(h);
      ext_len[i] = ext_len[i] + units;
    end else begin
      if (ext_count >= 64) return ffea_pkg::ST_FULL;
      for (int unsigned k = ext_count; k > i; k--) begin
        ext_start[k] = ext_start[k-1];
        ext_len[k] = ext_len[k-1];
      end
      ext_start[i] = 23'(h);
      ext_len[i] = units;
      ext_count++;
    end
    return ffea_pkg::ST_OK;
  endfunction

  function void note_input(bit [87:0] beat);
    bit [1:0] mode;
    bit [2:0] st;
    bit [23:0] off, sz;
    mode = beat[1:0];
    st = ffea_pkg::ST_OK;
    off = '0;
    sz = '0;
    case (mode)
      ffea_pkg::MODE_ALLOC: begin
        st = alloc(beat[33:2], off, sz);
        if (st == ffea_pkg::ST_OK) begin
          live_off.push_back(off);
          live_units.push_back(sz);
          ok_allocs++;
        end
      end
      ffea_pkg::MODE_FREE: begin
        st = free_blk(beat[57:34], beat[81:58]);
        if (st == ffea_pkg::ST_OK) ok_frees++;
      end
      ffea_pkg::MODE_INIT: table_init();
      default: ;
    endcase
    q_status.push_back(st);
    q_offset.push_back(off);
    q_units.push_back(sz);
  endfunction

  function void check_result(bit [55:0] beat);
    bit [2:0] es;
    bit [23:0] eo, eu;
    results_seen++;
    if (q_status.size() == 0) begin
      $error("result beat with no expectation: %h", beat);
      errors++;
      return;
    end
    es = q_status.pop_front();
    eo = q_offset.pop_front();
    eu = q_units.pop_front();
    if (beat[2:0] != es) begin
      $error("status expected %0d actual %0d", es, beat[2:0]);
      errors++;
    end
    if (beat[26:3] != eo) begin
      $error("result_offset expected %0d actual %0d", eo, beat[26:3]);
      errors++;
    end
    if (beat[50:27] != eu) begin
      $error("result_units expected %0d actual %0d", eu, beat[50:27]);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return q_status.size();
  endfunction
endclass

module tb_top;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        cfg_we;
  logic [23:0] cfg_wdata;

  alloc_scoreboard sb;
  bit stall_long;
  bit stall_go;
  bit rx_random;
  int unsigned beats_sent;

  first_fit_extent_allocator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  task automatic send_beat(bit [1:0] mode, bit [31:0] bytes, bit [23:0] payload,
                           bit [23:0] units);
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, units, payload, bytes, mode};
    do @(posedge clk); while (!in_tready);
    sb.note_input({6'd0, units, payload, bytes, mode});
    beats_sent++;
  endtask

  task automatic send_idle_gap();
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic alloc_beat(bit [31:0] bytes);
    send_beat(ffea_pkg::MODE_ALLOC, bytes, '0, '0);
  endtask

  task automatic free_beat(bit [23:0] payload, bit [23:0] units);
    send_beat(ffea_pkg::MODE_FREE, '0, payload, units);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_pool(bit [23:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.pool_reg = value;
    cfg_we <= 1'b0;
  endtask

  task automatic random_free();
    int unsigned idx;
    bit [23:0] off, un;
    if (sb.live_off.size() == 0) begin
      free_beat(24'($urandom_range(0, 300)), 24'($urandom_range(0, 40)));
      return;
    end
    idx = $urandom_range(0, sb.live_off.size() - 1);
    off = sb.live_off[idx];
    un = sb.live_units[idx];
    sb.live_off.delete(idx);
    sb.live_units.delete(idx);
    free_beat(off, un);
  endtask

  task automatic random_beat(bit [23:0] pool);
    int unsigned r;
    bit [31:0] b;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      b = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 16 * pool / 8 + 1);
      alloc_beat(b);
    end else if (r < 85) begin
      random_free();
    end else if (r < 92) begin
      free_beat(24'($urandom()), 24'($urandom()));
    end else if (r < 95) begin
      free_beat(24'($urandom_range(0, pool + 1)), 24'($urandom_range(0, 8)));
    end else if (r < 98) begin
      send_beat(ffea_pkg::MODE_INIT, $urandom(), 24'($urandom()), 24'($urandom()));
    end else begin
      send_beat(ffea_pkg::MODE_NONE, $urandom(), 24'($urandom()), 24'($urandom()));
    end
  endtask

  initial begin
    stall_long = 1'b0;
    wait (stall_go);
    stall_long = 1'b1;
    repeat (2000) @(posedge clk);
    stall_long = 1'b0;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_long) out_tready <= 1'b0;
      else if (rx_random) out_tready <= ($urandom_range(0, 99) < 70);
      else out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  initial begin
    bit [23:0] pools[5];
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    stall_go = 1'b0;
    rx_random = 1'b0;
    beats_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    alloc_beat(32'd0);
    alloc_beat(32'd1);
    alloc_beat(32'd16);
    alloc_beat(32'd17);
    alloc_beat(32'hFFFF_FFFF);
    free_beat(24'd0, 24'd2);
    free_beat(24'd5, 24'd0);
    free_beat(24'hFFFFFF, 24'hFFFFFF);
    free_beat(24'd8388608, 24'd1);
    free_beat(24'd100, 24'd3);
    send_beat(ffea_pkg::MODE_NONE, '1, '1, '1);
    send_beat(ffea_pkg::MODE_INIT, '0, '0, '0);
    write_pool(24'd2);
    send_beat(ffea_pkg::MODE_INIT, '0, '0, '0);
    alloc_beat(32'd1);
    alloc_beat(32'd1);
    free_beat(24'd1, 24'd2);
    free_beat(24'd1, 24'd2);
    free_beat(24'd1, 24'd3);
    write_pool(24'hFFFFFF);
    send_beat(ffea_pkg::MODE_INIT, '0, '0, '0);
    alloc_beat(32'd134217712);
    write_pool(24'd200);
    send_beat(ffea_pkg::MODE_INIT, '0, '0, '0);
    for (int k = 0; k < 66; k++) alloc_beat(32'd16);
    for (int k = 0; k < 66; k += 2) free_beat(24'(200 - 2 * k - 1), 24'd2);
    drain();

    rx_random = 1'b1;
    pools[0] = 24'd64;
    pools[1] = 24'd500;
    pools[2] = 24'd4096;
    pools[3] = 24'd8388608;
    pools[4] = 24'd3;
    for (int p = 0; p < 5; p++) begin
      write_pool(pools[p]);
      send_beat(ffea_pkg::MODE_INIT, '0, '0, '0);
      for (int k = 0; k < 160; k++) begin
        if (p == 1 && k == 40) stall_go = 1'b1;
        random_beat(pools[p]);
        if (!(p == 1 && k >= 40 && k < 48)) send_idle_gap();
        if (k == 100) drain();
      end
    end

    drain();
    $display("Run sent %0d beats and checked %0d results over several pool sizes.",
             beats_sent, sb.results_seen);
    $display("Successful allocations: %0d, successful frees: %0d.", sb.ok_allocs,
             sb.ok_frees);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
